// ===== hw/rtl/uvst_pkg.sv =====
// Package for the unique value set table: sizes, mode and status codes,
// and the structs that run between the cells and the control.
// No dependencies.
package uvst_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int ITEM_W      = 32;
	localparam int COUNT_OUT_W = 5;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		MODE_ADD      = 2'd0,
		MODE_REMOVE   = 2'd1,
		MODE_CONTAINS = 2'd2,
		MODE_CLEAR    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// ripple signals passed from one cell to the next
	typedef struct packed {
		logic                   hit;    // some earlier cell matched
		logic                   taken;  // some earlier cell is free
		logic [VALUE_WIDTH-1:0] rvalue; // value of the matching cell
	} uvst_chain_t;

	// controls broadcast to every cell
	typedef struct packed {
		logic look;    // compare key against stored value
		logic ins_en;  // lowest free cell stores the key
		logic rem_en;  // matching cell drops its entry
		logic clr_en;  // every cell drops its entry
	} uvst_ctl_t;

endpackage

// ===== hw/rtl/uvst_if.sv =====
// Valid/ready channel interfaces for the unique value set table.
// Depends on uvst_pkg for field widths.
interface uvst_item_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    mode;
	logic [uvst_pkg::ITEM_W-1:0]   item_value;

	modport source (output valid, output mode, output item_value, input ready);
	modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface uvst_result_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       status;
	logic                             found;
	logic [uvst_pkg::ITEM_W-1:0]      removed_value;
	logic [uvst_pkg::COUNT_OUT_W-1:0] entry_count;

	modport source (output valid, output status, output found, output removed_value,
		output entry_count, input ready);
	modport sink   (input valid, input status, input found, input removed_value,
		input entry_count, output ready);
endinterface

// ===== hw/rtl/uvst_cell.sv =====
// One slot of the set table: stored value, valid mark and match flag.
// Passes hit, free-slot and removed-value signals on to the next cell.
// Depends on uvst_pkg.
module uvst_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  uvst_pkg::uvst_ctl_t              ctl,
	input  logic [uvst_pkg::VALUE_WIDTH-1:0] key,
	input  uvst_pkg::uvst_chain_t            chain_in,
	output uvst_pkg::uvst_chain_t            chain_out
);
	import uvst_pkg::*;

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   valid_q;
	logic                   match_q;
	logic                   claim;

	// first free cell in the row takes the insert
	assign claim = !valid_q && !chain_in.taken;

	assign chain_out.hit    = chain_in.hit | match_q;
	assign chain_out.taken  = chain_in.taken | !valid_q;
	assign chain_out.rvalue = chain_in.rvalue | (match_q ? value_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.look) begin
				match_q <= valid_q && (value_q == key);
			end
			if (ctl.clr_en) begin
				valid_q <= 1'b0;
			end else if (ctl.rem_en && match_q) begin
				valid_q <= 1'b0;
			end else if (ctl.ins_en && claim) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins_en && claim) begin
			value_q <= key;
		end
	end

endmodule

// ===== hw/rtl/unique_value_set_table_top.sv =====
// Top level of the unique value set table: control, result register and
// the row of uvst_cell slots. Depends on uvst_pkg, uvst_if and uvst_cell.
//
//   port    dir   fields                                          role
//   item    sink  mode, item_value                                request word
//   result  src   status, found, removed_value, entry_count       response word
//
// For each word, the accept edge loads every cell's match flag, the
// next cycle resolves hit and lowest free slot along the cell row and
// updates cells, count and the result register.
// Reset empties the table (valid marks and count) at once; no sweep.
// A stalled result holds the next request off until it is taken.
module unique_value_set_table_top (
	input logic          clk,
	input logic          arst_n,
	uvst_item_if.sink    item,
	uvst_result_if.source result
);
	import uvst_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_APPLY = 2'b10
	} state_t;

	state_t                 state_q;
	logic [1:0]             mode_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_nx;

	logic                   res_valid_q;
	logic [1:0]             status_q;
	logic                   found_q;
	logic [ITEM_W-1:0]      removed_q;

	logic                   item_fire;
	logic                   apply;
	logic                   hit_all;
	logic                   full;
	logic [VALUE_WIDTH-1:0] key;
	logic [1:0]             status_nx;
	logic                   found_nx;
	logic [ITEM_W-1:0]      removed_nx;
	uvst_ctl_t              ctl;
	uvst_chain_t            chain [CAPACITY+1];

	assign item.ready = (state_q == S_IDLE) && (!res_valid_q || result.ready);
	assign item_fire  = item.valid && item.ready;
	assign apply      = (state_q == S_APPLY);

	assign key = item_fire ? VALUE_WIDTH'(item.item_value) : key_q;

	assign hit_all = chain[CAPACITY].hit;
	assign full    = !chain[CAPACITY].taken;

	assign ctl.look   = item_fire;
	assign ctl.ins_en = apply && (mode_q == MODE_ADD) && !hit_all;
	assign ctl.rem_en = apply && (mode_q == MODE_REMOVE);
	assign ctl.clr_en = apply && (mode_q == MODE_CLEAR);

	assign chain[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		uvst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key       (key),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	always_comb begin
		status_nx  = ST_DONE;
		found_nx   = 1'b0;
		removed_nx = '0;
		count_nx   = count_q;
		case (mode_q)
			MODE_ADD: begin
				if (hit_all) begin
					status_nx = ST_PRESENT;
					found_nx  = 1'b1;
				end else if (full) begin
					status_nx = ST_FULL;
				end else begin
					count_nx = count_q + CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (hit_all) begin
					found_nx   = 1'b1;
					removed_nx = ITEM_W'(chain[CAPACITY].rvalue);
					count_nx   = count_q - CNT_W'(1);
				end else begin
					status_nx = ST_ABSENT;
				end
			end
			MODE_CONTAINS: begin
				if (hit_all) begin
					found_nx = 1'b1;
				end else begin
					status_nx = ST_ABSENT;
				end
			end
			default: begin
				count_nx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (apply) begin
				count_q     <= count_nx;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			mode_q <= item.mode;
			key_q  <= VALUE_WIDTH'(item.item_value);
		end
		if (apply) begin
			status_q  <= status_nx;
			found_q   <= found_nx;
			removed_q <= removed_nx;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.status        = status_q;
	assign result.found         = found_q;
	assign result.removed_value = removed_q;
	assign result.entry_count   = COUNT_OUT_W'(count_q);

endmodule

// ===== hw/rtl/uvst_checker.sv =====
// Port-level checks for the unique value set table, bound to the top level.
// Depends on uvst_pkg.
module uvst_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_valid,
	input logic                             item_ready,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic [1:0]                       status,
	input logic                             found,
	input logic [uvst_pkg::COUNT_OUT_W-1:0] entry_count
);
	import uvst_pkg::*;

	// a held result stays up until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	// one word in flight: no new accept in the update cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request accepted during update cycle");

	// every accepted word shows its result once its update cycle is done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |-> ##2 res_valid)
		else $error("result missing after accept");

	// found agrees with status
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((status == ST_PRESENT) ? found
			: ((status == ST_ABSENT || status == ST_FULL) ? !found : 1'b1)))
		else $error("found flag disagrees with status");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_FULL) |-> (entry_count == COUNT_OUT_W'(CAPACITY)))
		else $error("full reported with free slots");

endmodule

bind unique_value_set_table_top uvst_checker u_uvst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.status      (result.status),
	.found       (result.found),
	.entry_count (result.entry_count)
);

// ===== verif/tb_unique_value_set_table_top.sv =====
// Testbench for unique_value_set_table_top: directed table then weighted random
// add/remove/contains/clear traffic, checked against an in-bench set model.
// Depends on uvst_pkg, uvst_if and the RTL top level.
module tb_unique_value_set_table_top;
	import uvst_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int POOL_N      = 24;
	localparam int PHASE_WORDS = 233;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		status_t                status;
		logic                   found;
		logic [ITEM_W-1:0]      removed_value;
		logic [COUNT_OUT_W-1:0] entry_count;
	} set_reply_t;

	typedef struct {
		mode_t             mode;
		logic [ITEM_W-1:0] value;
		bit                typed;
		set_reply_t        reply;
	} dir_row_t;

	localparam int DIR_N = 28;

	// typed replies only where obvious; typed == 0 rows fall back to the model
	dir_row_t dir_rows [DIR_N] = '{
		'{MODE_CONTAINS, 32'h0000_0000, 1'b1, '{ST_ABSENT, 1'b0, 32'h0, 5'd0}},
		'{MODE_REMOVE,   32'hFFFF_FFFF, 1'b1, '{ST_ABSENT, 1'b0, 32'h0, 5'd0}},
		'{MODE_ADD,      32'h0000_0000, 1'b1, '{ST_DONE, 1'b0, 32'h0, 5'd1}},
		'{MODE_ADD,      32'h0000_0000, 1'b1, '{ST_PRESENT, 1'b1, 32'h0, 5'd1}},
		'{MODE_ADD,      32'hFFFF_FFFF, 1'b1, '{ST_DONE, 1'b0, 32'h0, 5'd2}},
		'{MODE_CONTAINS, 32'hFFFF_FFFF, 1'b1, '{ST_DONE, 1'b1, 32'h0, 5'd2}},
		'{MODE_REMOVE,   32'h0000_0000, 1'b1, '{ST_DONE, 1'b1, 32'h0, 5'd1}},
		'{MODE_ADD,      32'h0000_0001, 1'b0, '0},
		'{MODE_ADD,      32'h8000_0000, 1'b0, '0},
		'{MODE_ADD,      32'h5555_5555, 1'b0, '0},
		'{MODE_ADD,      32'hAAAA_AAAA, 1'b0, '0},
		'{MODE_ADD,      32'h0000_FFFF, 1'b0, '0},
		'{MODE_ADD,      32'hFFFF_0000, 1'b0, '0},
		'{MODE_ADD,      32'h1234_5678, 1'b0, '0},
		'{MODE_ADD,      32'h7FFF_FFFF, 1'b0, '0},
		'{MODE_ADD,      32'hFFFF_FFFE, 1'b0, '0},
		'{MODE_ADD,      32'h0000_0002, 1'b0, '0},
		'{MODE_ADD,      32'h0F0F_0F0F, 1'b0, '0},
		'{MODE_ADD,      32'hF0F0_F0F0, 1'b0, '0},
		'{MODE_ADD,      32'h00FF_00FF, 1'b0, '0},
		'{MODE_ADD,      32'hFF00_FF00, 1'b0, '0},
		'{MODE_ADD,      32'hDEAD_BEEF, 1'b0, '0},
		'{MODE_ADD,      32'h0000_0000, 1'b1, '{ST_FULL, 1'b0, 32'h0, 5'd16}},
		'{MODE_ADD,      32'hFFFF_FFFF, 1'b1, '{ST_PRESENT, 1'b1, 32'h0, 5'd16}},
		'{MODE_REMOVE,   32'hFFFF_FFFF, 1'b1, '{ST_DONE, 1'b1, 32'hFFFF_FFFF, 5'd15}},
		'{MODE_ADD,      32'h0000_0000, 1'b0, '0},
		'{MODE_CLEAR,    32'h1357_9BDF, 1'b1, '{ST_DONE, 1'b0, 32'h0, 5'd0}},
		'{MODE_CONTAINS, 32'hDEAD_BEEF, 1'b1, '{ST_ABSENT, 1'b0, 32'h0, 5'd0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	uvst_item_if   item_ch ();
	uvst_result_if result_ch ();

	unique_value_set_table_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the table
	logic [VALUE_WIDTH-1:0] tbl_vals [CAPACITY];
	bit                     tbl_used [CAPACITY];
	int                     tbl_cnt;

	set_reply_t reply_q [$];
	int         fail_cnt;
	int         cycle_cnt;
	int         send_idle_pct;
	int         recv_stall_pct;
	bit         word_typed;
	set_reply_t word_reply;
	logic [ITEM_W-1:0] value_pool [POOL_N];

	function automatic set_reply_t apply_set_op(mode_t m, logic [ITEM_W-1:0] raw);
		logic [VALUE_WIDTH-1:0] key;
		int         hit;
		int         slot;
		int         i;
		set_reply_t r;
		key  = raw[VALUE_WIDTH-1:0];
		r    = '0;
		hit  = -1;
		slot = -1;
		for (i = 0; i < CAPACITY; i++) begin
			if (tbl_used[i] && tbl_vals[i] == key && hit < 0)
				hit = i;
			if (!tbl_used[i] && slot < 0)
				slot = i;
		end
		r.status = ST_DONE;
		case (m)
			MODE_ADD: begin
				if (hit >= 0) begin
					r.status = ST_PRESENT;
					r.found  = 1'b1;
				end else if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					tbl_vals[slot] = key;
					tbl_used[slot] = 1'b1;
					tbl_cnt++;
				end
			end
			MODE_REMOVE: begin
				if (hit >= 0) begin
					r.found         = 1'b1;
					r.removed_value = ITEM_W'(tbl_vals[hit]);
					tbl_used[hit]   = 1'b0;
					if (tbl_cnt > 0)
						tbl_cnt--;
				end else begin
					r.status = ST_ABSENT;
				end
			end
			MODE_CONTAINS: begin
				if (hit >= 0)
					r.found = 1'b1;
				else
					r.status = ST_ABSENT;
			end
			default: begin
				for (i = 0; i < CAPACITY; i++)
					tbl_used[i] = 1'b0;
				tbl_cnt = 0;
			end
		endcase
		r.entry_count = COUNT_OUT_W'(tbl_cnt);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			fail_cnt++;
			if (fail_cnt <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
		end
	endtask

	// accepted requests feed the model first, then any accepted response is checked
	always @(posedge clk) begin
		set_reply_t predicted;
		set_reply_t exp_r;
		if (arst_n) begin
			cycle_cnt++;
			if (cycle_cnt > CYCLE_LIMIT) begin
				$display("FAIL unique_value_set_table_top");
				$finish;
			end
			if (item_ch.valid && item_ch.ready) begin
				predicted = apply_set_op(mode_t'(item_ch.mode), item_ch.item_value);
				reply_q.push_back(word_typed ? word_reply : predicted);
			end
			if (result_ch.valid && result_ch.ready) begin
				if (reply_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("%0t: response word with nothing expected", $time);
				end else begin
					exp_r = reply_q.pop_front();
					check_field("status", 32'(exp_r.status), 32'(result_ch.status));
					check_field("found", 32'(exp_r.found), 32'(result_ch.found));
					check_field("removed_value", 32'(exp_r.removed_value),
						32'(result_ch.removed_value));
					check_field("entry_count", 32'(exp_r.entry_count),
						32'(result_ch.entry_count));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_word(input mode_t m, input logic [ITEM_W-1:0] v, input bit typed,
		input set_reply_t r);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_ch.mode       = m;
		item_ch.item_value = v;
		word_typed         = typed;
		word_reply         = r;
		item_ch.valid      = 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	// hold the request side off until every response is back
	task automatic drain_replies();
		item_ch.valid = 1'b0;
		while (reply_q.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_word();
		int    pick;
		mode_t m;
		logic [ITEM_W-1:0] v;
		pick = $urandom_range(99);
		if (pick < 46)
			m = MODE_ADD;
		else if (pick < 72)
			m = MODE_REMOVE;
		else if (pick < 98)
			m = MODE_CONTAINS;
		else
			m = MODE_CLEAR;
		if ($urandom_range(99) < 15)
			v = $urandom;
		else
			v = value_pool[$urandom_range(POOL_N - 1)];
		send_word(m, v, 1'b0, '0);
	endtask

	initial begin
		int ph;
		int sent;
		int i;
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.mode       = MODE_ADD;
		item_ch.item_value = '0;
		result_ch.ready    = 1'b0;
		word_typed         = 1'b0;
		word_reply         = '0;
		fail_cnt           = 0;
		cycle_cnt          = 0;
		tbl_cnt            = 0;
		for (i = 0; i < CAPACITY; i++) begin
			tbl_used[i] = 1'b0;
			tbl_vals[i] = '0;
		end
		value_pool[0] = '0;
		value_pool[1] = '1;
		for (i = 2; i < POOL_N; i++)
			value_pool[i] = $urandom;
		send_idle_pct  = 30;
		recv_stall_pct = 50;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < DIR_N; i++)
			send_word(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].reply);

		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct  = (ph == 0) ? 30 : (ph == 1) ? 50 : 0;
			recv_stall_pct = (ph == 0) ? 50 : (ph == 1) ? 30 : 0;
			sent = 0;
			while (sent < PHASE_WORDS) begin
				if ($urandom_range(99) < 12) begin
					// fill run: a burst of pool adds that pushes the table toward full
					for (i = 0; i < 18; i++)
						send_word(MODE_ADD, value_pool[$urandom_range(POOL_N - 1)], 1'b0, '0);
					sent += 18;
				end else begin
					send_random_word();
					sent++;
				end
			end
			drain_replies();
		end

		repeat (8) @(negedge clk);
		if (fail_cnt == 0)
			$display("PASS unique_value_set_table_top");
		else
			$display("FAIL unique_value_set_table_top");
		$finish;
	end

endmodule
